// File: rtl/spaceless_word_tokenizer_top_assert.svh
// assertion macros for the spaceless word tokenizer
`ifndef SPACELESS_WORD_TOKENIZER_TOP_ASSERT_SVH
`define SPACELESS_WORD_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SWT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/swt_pkg.sv
// shared types and constants of the spaceless word tokenizer
package swt_pkg;

    localparam int BYTE_W     = 8;
    localparam int DOC_W      = 32;
    localparam int START_W    = 32;
    localparam int LEN_W      = 8;
    localparam int RANK_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAP0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 3'd4;

    localparam logic [BYTE_W-1:0] SPACE_CHAR    = 8'h20;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 8'd255;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic               word_byte;
        logic               space_byte;
        logic               doc_last;
        logic [START_W-1:0] pos;
        logic [DOC_W-1:0]   doc;
    } item_t;

    // one finished token
    typedef struct packed {
        logic [DOC_W-1:0]   doc_index;
        logic [START_W-1:0] token_start;
        logic [LEN_W-1:0]   token_len;
        logic               is_word;
        logic [RANK_W-1:0]  token_rank;
        logic               ends_document;
        logic               run_last;
    } token_t;

    // back-end status seen by the top level
    typedef struct packed {
        logic              pend_valid;
        logic [RANK_W-1:0] pend_rank;
        logic              pend_run_last;
    } back_status_t;

endpackage

// File: rtl/swt_ifs.sv
// channel interfaces of the spaceless word tokenizer

// text byte channel
interface swt_byte_if;
    logic                        valid;
    logic                        ready;
    logic [swt_pkg::BYTE_W-1:0]  text_byte;
    logic                        doc_last;

    modport source (output valid, output text_byte, output doc_last, input ready);
    modport sink   (input valid, input text_byte, input doc_last, output ready);
endinterface

// token result channel
interface swt_token_if;
    logic                         valid;
    logic                         ready;
    logic [swt_pkg::DOC_W-1:0]    doc_index;
    logic [swt_pkg::START_W-1:0]  token_start;
    logic [swt_pkg::LEN_W-1:0]    token_len;
    logic                         is_word;
    logic [swt_pkg::RANK_W-1:0]   token_rank;
    logic                         ends_document;
    logic                         run_last;

    modport source (output valid, output doc_index, output token_start, output token_len,
                    output is_word, output token_rank, output ends_document,
                    output run_last, input ready);
    modport sink   (input valid, input doc_index, input token_start, input token_len,
                    input is_word, input token_rank, input ends_document,
                    input run_last, output ready);
endinterface

// configuration write channel
interface swt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [swt_pkg::CFG_IDX_W-1:0]   index;
    logic [swt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/swt_front.sv
// front end: configuration registers, byte classification, position and document counters
module swt_front #(
    parameter int POSITION_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    swt_byte_if.sink               byte_ch,
    swt_cfg_if.sink                cfg_ch,
    output logic                   push_valid,
    input  logic                   push_ready,
    output swt_pkg::item_t         push_item,
    output logic [swt_pkg::LEN_W-1:0] cap
);

    logic [swt_pkg::CFG_DATA_W-1:0] map0_reg, map0_next;
    logic [swt_pkg::CFG_DATA_W-1:0] map1_reg, map1_next;
    logic [swt_pkg::CFG_DATA_W-1:0] map2_reg, map2_next;
    logic [swt_pkg::CFG_DATA_W-1:0] map3_reg, map3_next;
    logic [swt_pkg::LEN_W-1:0]      max_len_reg, max_len_next;
    logic [POSITION_BITS-1:0]       pos_reg, pos_next;
    logic [swt_pkg::DOC_W-1:0]      doc_reg, doc_next;
    logic [4*swt_pkg::CFG_DATA_W-1:0] class_map;
    logic                           accept;

    // config writes are always taken
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        map0_next    = map0_reg;
        map1_next    = map1_reg;
        map2_next    = map2_reg;
        map3_next    = map3_reg;
        max_len_next = max_len_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                swt_pkg::REG_MAP0:    map0_next = cfg_ch.data;
                swt_pkg::REG_MAP1:    map1_next = cfg_ch.data;
                swt_pkg::REG_MAP2:    map2_next = cfg_ch.data;
                swt_pkg::REG_MAP3:    map3_next = cfg_ch.data;
                swt_pkg::REG_MAX_LEN: max_len_next = cfg_ch.data[swt_pkg::LEN_W-1:0];
                default:              ;
            endcase
        end
    end

    // a zero cap behaves as a cap of one
    assign cap = (max_len_reg == '0) ? swt_pkg::LEN_W'(1) : max_len_reg;

    // byte handshake follows the queue
    assign accept        = byte_ch.valid && push_ready;
    assign byte_ch.ready = push_ready;
    assign push_valid    = byte_ch.valid;

    // word class lookup over all 256 byte values
    assign class_map = {map3_reg, map2_reg, map1_reg, map0_reg};

    always_comb
    begin
        push_item.word_byte  = class_map[byte_ch.text_byte];
        push_item.space_byte = (byte_ch.text_byte == swt_pkg::SPACE_CHAR);
        push_item.doc_last   = byte_ch.doc_last;
        push_item.pos        = swt_pkg::START_W'(pos_reg);
        push_item.doc        = doc_reg;
    end

    // position restarts and document count steps on the last byte
    always_comb
    begin
        pos_next = pos_reg;
        doc_next = doc_reg;
        if (accept)
        begin
            if (byte_ch.doc_last)
            begin
                pos_next = '0;
                doc_next = doc_reg + swt_pkg::DOC_W'(1);
            end
            else
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map0_reg    <= '0;
            map1_reg    <= '0;
            map2_reg    <= '0;
            map3_reg    <= '0;
            max_len_reg <= swt_pkg::MAX_LEN_RESET;
            pos_reg     <= '0;
            doc_reg     <= '0;
        end
        else
        begin
            map0_reg    <= map0_next;
            map1_reg    <= map1_next;
            map2_reg    <= map2_next;
            map3_reg    <= map3_next;
            max_len_reg <= max_len_next;
            pos_reg     <= pos_next;
            doc_reg     <= doc_next;
        end
    end

endmodule

// File: rtl/swt_queue.sv
// short register queue between front and back
module swt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  swt_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output swt_pkg::item_t pop_item
);

    swt_pkg::item_t                 entry_reg [swt_pkg::QDEPTH];
    logic [swt_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [swt_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [swt_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != swt_pkg::QCNT_W'(swt_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == swt_pkg::QPTR_W'(swt_pkg::QDEPTH - 1)) ? '0
                        : wr_ptr_reg + swt_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == swt_pkg::QPTR_W'(swt_pkg::QDEPTH - 1)) ? '0
                        : rd_ptr_reg + swt_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + swt_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - swt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/swt_back.sv
// back end: token state machine, token rank and output staging
module swt_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  swt_pkg::item_t            pop_item,
    input  logic [swt_pkg::LEN_W-1:0] cap,
    swt_token_if.source               token_ch,
    output swt_pkg::back_status_t     status
);

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WORD  = 2'd1;
    localparam logic [1:0] MODE_SEP   = 2'd2;
    localparam logic [1:0] MODE_SPACE = 2'd3;

    logic [1:0]                  mode_reg, mode_next;
    logic [swt_pkg::START_W-1:0] start_reg, start_next;
    logic [swt_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [swt_pkg::RANK_W-1:0]  rank_reg, rank_next;
    logic                        out_valid_reg, out_valid_next;
    swt_pkg::token_t             out_tok_reg, out_tok_next;
    logic                        pend_valid_reg, pend_valid_next;
    swt_pkg::token_t             pend_tok_reg, pend_tok_next;

    logic                        consume;
    logic                        move_pend;
    logic                        a_valid;
    logic                        a_word;
    logic [swt_pkg::START_W-1:0] a_start;
    logic [swt_pkg::LEN_W-1:0]   a_len;
    logic                        b_valid;
    logic [1:0]                  mode_s;
    logic [swt_pkg::START_W-1:0] start_s;
    logic [swt_pkg::LEN_W-1:0]   len_s;
    logic                        restart;
    swt_pkg::token_t             tok_a;
    swt_pkg::token_t             tok_b;

    // token state machine for the byte at the queue head
    always_comb
    begin
        a_valid = 1'b0;
        a_word  = 1'b0;
        a_start = start_reg;
        a_len   = len_reg;
        mode_s  = mode_reg;
        start_s = start_reg;
        len_s   = len_reg;
        restart = 1'b0;
        case (mode_reg)
            MODE_WORD:
            begin
                if (pop_item.word_byte && (len_reg < cap))
                begin
                    len_s = len_reg + swt_pkg::LEN_W'(1);
                end
                else
                begin
                    a_valid = 1'b1;
                    a_word  = 1'b1;
                    restart = 1'b1;
                end
            end
            MODE_SEP:
            begin
                if (!pop_item.word_byte && (len_reg < cap))
                begin
                    len_s = len_reg + swt_pkg::LEN_W'(1);
                end
                else
                begin
                    a_valid = 1'b1;
                    restart = 1'b1;
                end
            end
            MODE_SPACE:
            begin
                if (pop_item.word_byte)
                begin
                    // pending space is dropped, word starts here
                    mode_s  = MODE_WORD;
                    start_s = pop_item.pos;
                    len_s   = swt_pkg::LEN_W'(1);
                end
                else if (cap > swt_pkg::LEN_W'(1))
                begin
                    // separator opens at the space and takes this byte
                    mode_s = MODE_SEP;
                    len_s  = swt_pkg::LEN_W'(2);
                end
                else
                begin
                    // cap of one: the space stands alone
                    a_valid = 1'b1;
                    a_len   = swt_pkg::LEN_W'(1);
                    restart = 1'b1;
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        // open a new token at this byte
        if (restart)
        begin
            start_s = pop_item.pos;
            if (pop_item.word_byte)
            begin
                mode_s = MODE_WORD;
                len_s  = swt_pkg::LEN_W'(1);
            end
            else if (pop_item.space_byte)
            begin
                mode_s = MODE_SPACE;
                len_s  = '0;
            end
            else
            begin
                mode_s = MODE_SEP;
                len_s  = swt_pkg::LEN_W'(1);
            end
        end

        b_valid = pop_item.doc_last && (mode_s != MODE_IDLE);

        // token closed mid-byte
        tok_a.doc_index     = pop_item.doc;
        tok_a.token_start   = a_start;
        tok_a.token_len     = a_len;
        tok_a.is_word       = a_word;
        tok_a.token_rank    = rank_reg;
        tok_a.ends_document = 1'b0;
        tok_a.run_last      = !b_valid;

        // token closed by the end of the document
        tok_b.doc_index     = pop_item.doc;
        tok_b.token_start   = start_s;
        tok_b.token_len     = (mode_s == MODE_SPACE) ? swt_pkg::LEN_W'(1) : len_s;
        tok_b.is_word       = (mode_s == MODE_WORD);
        tok_b.token_rank    = rank_reg + swt_pkg::RANK_W'(a_valid);
        tok_b.ends_document = 1'b1;
        tok_b.run_last      = 1'b1;
    end

    // a byte is taken only when the staging has room for both possible tokens
    assign move_pend = pend_valid_reg && (!out_valid_reg || token_ch.ready);
    assign consume   = pop_valid && !pend_valid_reg && (!out_valid_reg || token_ch.ready);
    assign pop_ready = consume;

    // state and staging update
    always_comb
    begin
        mode_next       = mode_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        rank_next       = rank_reg;
        out_valid_next  = out_valid_reg;
        out_tok_next    = out_tok_reg;
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;

        if (out_valid_reg && token_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (move_pend)
        begin
            out_valid_next  = 1'b1;
            out_tok_next    = pend_tok_reg;
            pend_valid_next = 1'b0;
        end
        else if (consume)
        begin
            start_next = start_s;
            rank_next  = rank_reg + swt_pkg::RANK_W'(a_valid) + swt_pkg::RANK_W'(b_valid);
            if (pop_item.doc_last)
            begin
                mode_next = MODE_IDLE;
                len_next  = '0;
            end
            else
            begin
                mode_next = mode_s;
                len_next  = len_s;
            end
            if (a_valid || b_valid)
            begin
                out_valid_next = 1'b1;
                out_tok_next   = a_valid ? tok_a : tok_b;
            end
            if (a_valid && b_valid)
            begin
                pend_valid_next = 1'b1;
                pend_tok_next   = tok_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            start_reg      <= '0;
            len_reg        <= '0;
            rank_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            start_reg      <= start_next;
            len_reg        <= len_next;
            rank_reg       <= rank_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // token payload staging
    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        pend_tok_reg <= pend_tok_next;
    end

    // output beat
    assign token_ch.valid         = out_valid_reg;
    assign token_ch.doc_index     = out_tok_reg.doc_index;
    assign token_ch.token_start   = out_tok_reg.token_start;
    assign token_ch.token_len     = out_tok_reg.token_len;
    assign token_ch.is_word       = out_tok_reg.is_word;
    assign token_ch.token_rank    = out_tok_reg.token_rank;
    assign token_ch.ends_document = out_tok_reg.ends_document;
    assign token_ch.run_last      = out_tok_reg.run_last;

    assign status.pend_valid    = pend_valid_reg;
    assign status.pend_rank     = pend_tok_reg.token_rank;
    assign status.pend_run_last = pend_tok_reg.run_last;

endmodule

// File: rtl/spaceless_word_tokenizer_top.sv
// top level of the spaceless word tokenizer
// Splits a byte stream into word and separator tokens. One text byte is accepted per
// cycle on byte_ch while the queue has room; the front end classifies it against the
// word class map and stamps it with its offset and document number, then a two-entry
// queue hands it to the back end, whose token state machine retires one byte per cycle
// while its output staging has room. Each byte closes zero, one or two tokens. Tokens
// leave on token_ch at one beat per cycle while token_ch is ready, through an output
// register, and a byte that closes two tokens holds the back end while the second token
// moves from its holding register to the output. Configuration writes on cfg_ch are
// always taken and must only be issued while the block is idle. POSITION_BITS sets the
// width of the in-document byte counter; offsets wrap at that width and are reported
// in the low 32 bits of token_start.
`include "spaceless_word_tokenizer_top_assert.svh"

module spaceless_word_tokenizer_top #(
    parameter int POSITION_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    swt_byte_if.sink    byte_ch,
    swt_token_if.source token_ch,
    swt_cfg_if.sink     cfg_ch
);

    logic                      push_valid;
    logic                      push_ready;
    swt_pkg::item_t            push_item;
    logic                      pop_valid;
    logic                      pop_ready;
    swt_pkg::item_t            pop_item;
    logic [swt_pkg::LEN_W-1:0] cap;
    swt_pkg::back_status_t     back_status;

    // classification and counters
    swt_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .cfg_ch     (cfg_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .cap        (cap)
    );

    // decoupling queue
    swt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // token state machine and output staging
    swt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .cap       (cap),
        .token_ch  (token_ch),
        .status    (back_status)
    );

    // checks on the output staging
    `SWT_ASSERT_IMPL(a_pend_has_out, back_status.pend_valid, token_ch.valid, "held token without output token")
    `SWT_ASSERT_IMPL(a_pend_order, back_status.pend_valid, (back_status.pend_rank == token_ch.token_rank + swt_pkg::RANK_W'(1)) && !token_ch.run_last && back_status.pend_run_last, "held token out of order")
    `SWT_ASSERT_NEXT(a_pend_moves, back_status.pend_valid && token_ch.ready, token_ch.valid && !back_status.pend_valid, "held token not forwarded")
    `SWT_ASSERT_IMPL(a_end_is_last, token_ch.valid && token_ch.ends_document, token_ch.run_last, "document end token not last of its byte")

endmodule

// File: sim/tb.sv
// testbench for the spaceless word tokenizer: predicted tokens checked beat by beat under random stalls
module tb;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_SEP, SCAN_SPACE} scan_mode_t;

    // word class maps: digits in map 0, both letter cases in map 1
    localparam logic [63:0] DIGIT_MAP = 64'h03FF_0000_0000_0000;
    localparam logic [63:0] ALPHA_MAP = 64'h07FF_FFFE_07FF_FFFE;

    // token predictor and store of expected tokens
    class token_scoreboard;
        logic [63:0]                 word_map [4];
        logic [swt_pkg::LEN_W-1:0]   max_len;
        scan_mode_t                  mode;
        logic [swt_pkg::START_W-1:0] open_start;
        logic [swt_pkg::LEN_W-1:0]   open_len;
        logic [swt_pkg::START_W-1:0] byte_pos;
        logic [swt_pkg::DOC_W-1:0]   doc_count;
        logic [swt_pkg::RANK_W-1:0]  token_count;
        swt_pkg::token_t             expected_tokens [$];
        int                          mismatches;

        function new();
            foreach (word_map[i])
                word_map[i] = '0;
            max_len     = swt_pkg::MAX_LEN_RESET;
            mode        = SCAN_IDLE;
            open_start  = '0;
            open_len    = '0;
            byte_pos    = '0;
            doc_count   = '0;
            token_count = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [swt_pkg::CFG_IDX_W-1:0] idx,
                              logic [swt_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                swt_pkg::REG_MAP0:    word_map[0] = data;
                swt_pkg::REG_MAP1:    word_map[1] = data;
                swt_pkg::REG_MAP2:    word_map[2] = data;
                swt_pkg::REG_MAP3:    word_map[3] = data;
                swt_pkg::REG_MAX_LEN: max_len = data[swt_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function bit is_word_byte(logic [7:0] b);
            return word_map[b[7:6]][b[5:0]];
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void close_token(logic word, logic ends);
            swt_pkg::token_t tok;
            tok.doc_index     = doc_count;
            tok.token_start   = open_start;
            tok.token_len     = open_len;
            tok.is_word       = word;
            tok.token_rank    = token_count;
            tok.ends_document = ends;
            tok.run_last      = 1'b0;
            expected_tokens.push_back(tok);
            token_count = token_count + swt_pkg::RANK_W'(1);
        endfunction

        // advance the token state machine by one accepted byte
        function void note_byte(logic [7:0] b, logic last);
            logic                        w;
            logic [swt_pkg::LEN_W-1:0]   cap;
            logic [swt_pkg::START_W-1:0] pos;
            int                          first;
            bit                          done;
            swt_pkg::token_t             tok;
            w     = is_word_byte(b);
            cap   = (max_len == '0) ? swt_pkg::LEN_W'(1) : max_len;
            pos   = byte_pos;
            first = expected_tokens.size();
            done  = 1'b0;
            while (!done)
            begin
                case (mode)
                    SCAN_WORD:
                    begin
                        if (w && open_len < cap)
                        begin
                            open_len++;
                            done = 1'b1;
                        end
                        else
                        begin
                            close_token(1'b1, 1'b0);
                            mode = SCAN_IDLE;
                        end
                    end
                    SCAN_SEP:
                    begin
                        if (!w && open_len < cap)
                        begin
                            open_len++;
                            done = 1'b1;
                        end
                        else
                        begin
                            close_token(1'b0, 1'b0);
                            mode = SCAN_IDLE;
                        end
                    end
                    SCAN_SPACE:
                    begin
                        if (w)
                        begin
                            // pending space dropped, word starts here
                            mode       = SCAN_WORD;
                            open_start = pos;
                            open_len   = swt_pkg::LEN_W'(1);
                            done       = 1'b1;
                        end
                        else
                        begin
                            // separator opens at the space, byte is looked at again
                            mode     = SCAN_SEP;
                            open_len = swt_pkg::LEN_W'(1);
                        end
                    end
                    default:
                    begin
                        open_start = pos;
                        if (w)
                        begin
                            mode     = SCAN_WORD;
                            open_len = swt_pkg::LEN_W'(1);
                        end
                        else if (b == swt_pkg::SPACE_CHAR)
                        begin
                            mode     = SCAN_SPACE;
                            open_len = '0;
                        end
                        else
                        begin
                            mode     = SCAN_SEP;
                            open_len = swt_pkg::LEN_W'(1);
                        end
                        done = 1'b1;
                    end
                endcase
            end

            // document end flushes the open token
            if (last)
            begin
                case (mode)
                    SCAN_WORD: close_token(1'b1, 1'b1);
                    SCAN_SEP:  close_token(1'b0, 1'b1);
                    SCAN_SPACE:
                    begin
                        open_len = swt_pkg::LEN_W'(1);
                        close_token(1'b0, 1'b1);
                    end
                    default: ;
                endcase
                mode     = SCAN_IDLE;
                open_len = '0;
                byte_pos = '0;
                doc_count++;
            end
            else
            begin
                byte_pos = pos + swt_pkg::START_W'(1);
            end

            if (expected_tokens.size() > first)
            begin
                tok = expected_tokens.pop_back();
                tok.run_last = 1'b1;
                expected_tokens.push_back(tok);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_token(swt_pkg::token_t got);
            swt_pkg::token_t want;
            if (expected_tokens.size() == 0)
            begin
                $error("token with nothing expected: doc %0d start %0d rank %0d",
                       got.doc_index, got.token_start, got.token_rank);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("doc_index", 64'(want.doc_index), 64'(got.doc_index));
            compare_field("token_start", 64'(want.token_start), 64'(got.token_start));
            compare_field("token_len", 64'(want.token_len), 64'(got.token_len));
            compare_field("is_word", 64'(want.is_word), 64'(got.is_word));
            compare_field("token_rank", 64'(want.token_rank), 64'(got.token_rank));
            compare_field("ends_document", 64'(want.ends_document),
                          64'(got.ends_document));
            compare_field("run_last", 64'(want.run_last), 64'(got.run_last));
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    bit              no_idle;
    int              bytes_sent;
    token_scoreboard sb;

    swt_byte_if  byte_ch ();
    swt_token_if token_ch ();
    swt_cfg_if   cfg_ch ();

    spaceless_word_tokenizer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .token_ch (token_ch),
        .cfg_ch   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int roll;
        if (no_idle)
            return 0;
        roll = int'($urandom_range(0, 99));
        if (roll < 60)
            return 0;
        if (roll < 93)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 30));
    endfunction

    task automatic put_byte(logic [7:0] b, logic last);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.text_byte <= b;
        byte_ch.doc_last  <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // stop sending and wait for every expected token
    task automatic drain();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // write all five registers once the block has gone quiet
    task automatic set_config(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                              logic [63:0] m3, logic [7:0] cap);
        logic [swt_pkg::CFG_DATA_W-1:0] vals [5];
        logic [swt_pkg::CFG_IDX_W-1:0]  regs [5];
        drain();
        repeat (8) @(posedge clk);
        vals = '{m0, m1, m2, m3, {56'd0, cap}};
        regs = '{swt_pkg::REG_MAP0, swt_pkg::REG_MAP1, swt_pkg::REG_MAP2,
                 swt_pkg::REG_MAP3, swt_pkg::REG_MAX_LEN};
        for (int i = 0; i < 5; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_byte(bit want_word);
        logic [7:0] b;
        b = '0;
        repeat (64)
        begin
            b = 8'($urandom_range(0, 255));
            if (sb.is_word_byte(b) == want_word)
                return b;
        end
        return b;
    endfunction

    // one document built from word, separator and space-led runs plus some noise
    task automatic put_random_doc();
        logic [7:0] text [$];
        int         runs;
        int         kind;
        int         len;
        runs = int'($urandom_range(1, 10));
        repeat (runs)
        begin
            kind = int'($urandom_range(0, 99));
            len  = ($urandom_range(0, 99) < 3) ? int'($urandom_range(200, 300))
                                                : int'($urandom_range(1, 6));
            if (kind >= 40 && kind < 75)
                text.push_back(swt_pkg::SPACE_CHAR);
            repeat (len)
            begin
                if (kind < 60)
                    text.push_back(pick_byte(1'b1));
                else if (kind < 90)
                    text.push_back(pick_byte(1'b0));
                else
                    text.push_back(8'($urandom_range(0, 255)));
            end
        end
        // trailing lone space now and then
        if ($urandom_range(0, 9) == 0)
            text.push_back(swt_pkg::SPACE_CHAR);
        foreach (text[i])
            put_byte(text[i], i == text.size() - 1);
    endtask

    task automatic put_random_text(int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            put_random_doc();
    endtask

    // token sink: check accepted beats, stall at random
    initial
    begin
        int              stall;
        swt_pkg::token_t got;
        stall = 0;
        token_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && token_ch.valid && token_ch.ready)
            begin
                got.doc_index     = token_ch.doc_index;
                got.token_start   = token_ch.token_start;
                got.token_len     = token_ch.token_len;
                got.is_word       = token_ch.is_word;
                got.token_rank    = token_ch.token_rank;
                got.ends_document = token_ch.ends_document;
                got.run_last      = token_ch.run_last;
                sb.check_token(got);
            end
            if (stall > 0)
            begin
                token_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                token_ch.ready <= 1'b1;
                stall = idle_len();
            end
        end
    end

    // stimulus
    initial
    begin
        sb         = new();
        no_idle    = 1'b0;
        bytes_sent = 0;
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.text_byte <= '0;
        byte_ch.doc_last  <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= swt_pkg::REG_MAP0;
        cfg_ch.data       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset maps: every byte is a separator
        put_text("a b");

        // directed: digits, letters and the top quarter of byte values are words
        set_config(DIGIT_MAP, ALPHA_MAP, '0, '1, 8'd255);
        put_text("hi yo");
        put_text("a ,b");
        put_text("x ");
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b1);
        put_text(" ");

        // space then separator under a cap of one
        set_config(DIGIT_MAP, ALPHA_MAP, '0, '1, 8'd1);
        put_text("a ,b");
        put_text("ab");

        // zero cap behaves as one
        set_config(DIGIT_MAP, ALPHA_MAP, '0, '1, 8'd0);
        put_text("ab.");

        // random phases
        set_config(DIGIT_MAP, ALPHA_MAP, '0, '1, 8'd255);
        put_random_text(250);

        set_config('1, '1, '1, '1, 8'd7);
        no_idle = 1'b1;
        put_random_text(150);
        no_idle = 1'b0;

        set_config('0, '0, '0, '0, 8'd4);
        put_random_text(150);

        set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 8'($urandom_range(1, 255)));
        put_random_text(120);
        drain();
        put_random_text(130);

        set_config(DIGIT_MAP, ALPHA_MAP, '0, '1, 8'd1);
        put_random_text(200);

        set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 8'd2);
        put_random_text(200);

        // wind down
        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/swt_pkg.sv
rtl/swt_ifs.sv
rtl/swt_front.sv
rtl/swt_queue.sv
rtl/swt_back.sv
rtl/spaceless_word_tokenizer_top.sv
sim/tb.sv
